>>> hdl/pimp_pkg.sv
package pimp_pkg;

    localparam int DEF_MAX_PAGES   = 64;
    localparam int DEF_VALUE_WIDTH = 64;

    localparam int FIELD_W    = 64;   // min, max, query value fields
    localparam int MASK_W     = 64;   // page bitmap
    localparam int SLOT_W     = 6;
    localparam int OP_W       = 3;
    localparam int PCNT_W     = 7;
    localparam int BO_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // query operations
    localparam logic [OP_W-1:0] OP_EQ    = 3'd0;
    localparam logic [OP_W-1:0] OP_NEQ   = 3'd1;
    localparam logic [OP_W-1:0] OP_GT    = 3'd2;
    localparam logic [OP_W-1:0] OP_GE    = 3'd3;
    localparam logic [OP_W-1:0] OP_LT    = 3'd4;
    localparam logic [OP_W-1:0] OP_LE    = 3'd5;
    localparam logic [OP_W-1:0] OP_RANGE = 3'd6;

    // boundary order codes
    localparam logic [BO_W-1:0] BO_NONE = 2'd0;
    localparam logic [BO_W-1:0] BO_ASC  = 2'd1;
    localparam logic [BO_W-1:0] BO_DESC = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_ORDER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_COUNTS_KNOWN = 2'd2;

    localparam logic [PCNT_W-1:0] PCNT_RESET = 7'd64;

endpackage

>>> hdl/pimp_req_if.sv
interface pimp_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic [pimp_pkg::SLOT_W-1:0]       page_slot;
    logic signed [pimp_pkg::FIELD_W-1:0] page_min;
    logic signed [pimp_pkg::FIELD_W-1:0] page_max;
    logic                              page_all_null;
    logic                              page_has_nulls;
    logic [pimp_pkg::OP_W-1:0]         query_op;
    logic signed [pimp_pkg::FIELD_W-1:0] query_value;
    logic signed [pimp_pkg::FIELD_W-1:0] query_high;
    logic                              value_is_null;

    modport source (
        output valid, req_type, page_slot, page_min, page_max, page_all_null,
               page_has_nulls, query_op, query_value, query_high, value_is_null,
        input  ready
    );
    modport sink (
        input  valid, req_type, page_slot, page_min, page_max, page_all_null,
               page_has_nulls, query_op, query_value, query_high, value_is_null,
        output ready
    );
endinterface

>>> hdl/pimp_res_if.sv
interface pimp_res_if;
    logic                         valid;
    logic                         ready;
    logic [pimp_pkg::MASK_W-1:0]  page_mask;

    modport source (output valid, page_mask, input ready);
    modport sink   (input valid, page_mask, output ready);
endinterface

>>> hdl/pimp_store.sv
// page statistics and non-null list memories; the stat read address is the
// registered list read data, so a list position reaches the stats through both read registers
module pimp_store #(
    parameter int MAX_PAGES   = pimp_pkg::DEF_MAX_PAGES,
    parameter int VALUE_WIDTH = pimp_pkg::DEF_VALUE_WIDTH,
    localparam int AW         = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_stat_we,
    input  logic [AW-1:0]                 i_stat_waddr,
    input  logic signed [VALUE_WIDTH-1:0] i_stat_wmin,
    input  logic signed [VALUE_WIDTH-1:0] i_stat_wmax,
    input  logic                          i_list_we,
    input  logic [AW-1:0]                 i_list_waddr,
    input  logic [AW-1:0]                 i_list_wpage,
    input  logic [AW-1:0]                 i_list_raddr,
    output logic [AW-1:0]                 o_list_page,
    output logic signed [VALUE_WIDTH-1:0] o_min,
    output logic signed [VALUE_WIDTH-1:0] o_max
);
    logic signed [VALUE_WIDTH-1:0] r_min_mem [MAX_PAGES];
    logic signed [VALUE_WIDTH-1:0] r_max_mem [MAX_PAGES];
    logic [AW-1:0]                 r_list_mem [MAX_PAGES];

    always_ff @(posedge i_clk) begin
        if (i_stat_we) begin
            r_min_mem[i_stat_waddr] <= i_stat_wmin;
            r_max_mem[i_stat_waddr] <= i_stat_wmax;
        end
        o_min <= r_min_mem[o_list_page];
        o_max <= r_max_mem[o_list_page];
    end

    always_ff @(posedge i_clk) begin
        if (i_list_we) begin
            r_list_mem[i_list_waddr] <= i_list_wpage;
        end
        o_list_page <= r_list_mem[i_list_raddr];
    end

endmodule

>>> hdl/page_index_minmax_pruner.sv
// page index min/max pruner: holds per-page signed min/max, an all-null flag
// and a has-nulls flag for up to MAX_PAGES pages, plus the load-ordered list
// of pages that are not all-null, and answers each query beat with a bitmap
// of pages that may hold matching rows (eq, not-eq, gt, ge, lt, le, set range).
// page 0 restarts the non-null list. a query whose answer comes from the flags
// alone (null eq/not-eq, not-eq with unknown null counts, op code seven) goes
// straight to the done state. every other query walks the non-null list
// through the list memory and then the statistics memory in a linear pass,
// and with ascending or descending order a binary search runs before that
// pass, each probe going through the check, list and stat states (eq/not-eq
// run two searches). set range runs a ge pass and an le pass. the answer
// sits in an output register, and load beats are taken while it waits.
// every answer is masked to the low page_count bits.
module page_index_minmax_pruner #(
    parameter int MAX_PAGES   = pimp_pkg::DEF_MAX_PAGES,
    parameter int VALUE_WIDTH = pimp_pkg::DEF_VALUE_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pimp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pimp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    pimp_req_if.sink                        i_req,
    pimp_res_if.source                      o_res
);
    localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW = $clog2(MAX_PAGES + 1);
    // signed list position: holds -1 up to MAX_PAGES
    localparam int IW = CW + 1;
    localparam int MW = pimp_pkg::MASK_W;

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_CHK, S_LIST, S_STAT, S_SCAN, S_PASS_END, S_DONE
    } t_state;

    // binary search flavors: run bounds (two halves), upward, downward
    typedef enum logic [1:0] {P_FIND1, P_FIND2, P_UP, P_DOWN} t_phase;

    t_state r_state;
    t_phase r_phase;

    // configuration
    logic [pimp_pkg::BO_W-1:0]   r_bo;
    logic [pimp_pkg::PCNT_W-1:0] r_pcnt;
    logic                        r_nck;

    // index state
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_null_pg;
    logic [MW-1:0] r_has_null;

    // query context
    logic [pimp_pkg::OP_W-1:0]     r_op;
    logic [pimp_pkg::OP_W-1:0]     r_kind;
    logic                          r_second;
    logic signed [VALUE_WIDTH-1:0] r_probe;
    logic signed [VALUE_WIDTH-1:0] r_high;
    logic [MW-1:0]                 r_acc;
    logic [MW-1:0]                 r_mask;
    logic [MW-1:0]                 r_res;

    // search bounds: ll/lr/ul/ur, or left/right in r_ll/r_lr
    logic signed [IW-1:0] r_ll, r_lr, r_ul, r_ur, r_mid, r_lo, r_hi;
    logic signed [IW-1:0] n_ll, n_lr, n_ul, n_ur;

    // scan pipeline
    logic signed [IW-1:0] r_scan_pos, r_pos1, r_pos2;
    logic                 r_v1, r_v2;
    logic [AW-1:0]        r_pg2;

    logic          r_out_valid;
    logic [MW-1:0] r_out_mask;

    // store ports
    logic                          stat_we, list_we;
    logic [AW-1:0]                 list_waddr, list_raddr, list_page;
    logic signed [VALUE_WIDTH-1:0] st_min, st_max;

    logic signed [IW-1:0] n_s, c_mid;
    logic                 c_fail;
    logic [MW-1:0]        all_mask;
    logic [pimp_pkg::PCNT_W-1:0] pn;

    logic in_beat, load_beat, query_beat, slot_ok;
    logic [CW-1:0] cnt0;
    logic          append;

    logic ordered, desc, strict, on_max, up, go, lead, tail;
    logic p_lt_min, p_gt_min, p_lt_max, p_gt_max, eq_min, eq_max, in_rng, hit;

    assign n_s     = $signed({1'b0, r_cnt});
    assign ordered = (r_bo == pimp_pkg::BO_ASC) || (r_bo == pimp_pkg::BO_DESC);
    assign desc    = (r_bo == pimp_pkg::BO_DESC);

    // all-pages mask from page_count, clamped to the store depth
    assign pn = (r_pcnt > pimp_pkg::PCNT_W'(MAX_PAGES)) ?
                pimp_pkg::PCNT_W'(MAX_PAGES) : r_pcnt;
    always_comb begin
        for (int b = 0; b < MW; b++) begin
            all_mask[b] = pimp_pkg::PCNT_W'(b) < pn;
        end
    end

    // load path
    assign i_req.ready = (r_state == S_IDLE);
    assign in_beat     = i_req.valid && i_req.ready;
    assign load_beat   = in_beat && (i_req.req_type == pimp_pkg::REQ_LOAD);
    assign query_beat  = in_beat && (i_req.req_type == pimp_pkg::REQ_QUERY);
    assign slot_ok     = {1'b0, i_req.page_slot} < (pimp_pkg::SLOT_W + 1)'(MAX_PAGES);
    assign cnt0        = (i_req.page_slot == '0) ? '0 : r_cnt;
    assign append      = !i_req.page_all_null && (cnt0 < CW'(MAX_PAGES));
    assign stat_we     = load_beat && slot_ok;
    assign list_we     = stat_we && append;
    assign list_waddr  = cnt0[AW-1:0];

    // probe position of the current search step
    always_comb begin
        c_fail = 1'b0;
        case (r_phase)
            P_FIND1: begin
                c_mid  = r_ll + ((r_lr - r_ll) >>> 1);
                c_fail = r_ll > r_lr;
            end
            P_FIND2: begin
                c_mid  = r_ul + ((r_ur - r_ul + IW'(1)) >>> 1);
                c_fail = r_ul > r_ur;
            end
            P_UP:    c_mid = r_ll + ((r_lr - r_ll) >>> 1);
            default: c_mid = r_ll + ((r_lr - r_ll + IW'(1)) >>> 1);
        endcase
    end

    assign list_raddr = (r_state == S_CHK) ? c_mid[AW-1:0] : r_scan_pos[AW-1:0];

    pimp_store #(
        .MAX_PAGES   (MAX_PAGES),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_stat_we    (stat_we),
        .i_stat_waddr (i_req.page_slot[AW-1:0]),
        .i_stat_wmin  (i_req.page_min[VALUE_WIDTH-1:0]),
        .i_stat_wmax  (i_req.page_max[VALUE_WIDTH-1:0]),
        .i_list_we    (list_we),
        .i_list_waddr (list_waddr),
        .i_list_wpage (i_req.page_slot[AW-1:0]),
        .i_list_raddr (list_raddr),
        .o_list_page  (list_page),
        .o_min        (st_min),
        .o_max        (st_max)
    );

    // probe against the page statistics
    assign p_lt_min = r_probe < st_min;
    assign p_gt_min = r_probe > st_min;
    assign p_lt_max = r_probe < st_max;
    assign p_gt_max = r_probe > st_max;
    assign eq_min   = r_probe == st_min;
    assign eq_max   = r_probe == st_max;

    assign strict = (r_kind == pimp_pkg::OP_GT) || (r_kind == pimp_pkg::OP_LT);
    assign on_max = (r_kind == pimp_pkg::OP_GT) || (r_kind == pimp_pkg::OP_GE);
    assign up     = on_max ? !desc : desc;
    assign go     = on_max ? (strict ? !p_lt_max : p_gt_max)
                           : (strict ? !p_gt_min : p_lt_min);
    // descending order swaps the min and max sides
    assign lead   = desc ? p_gt_max : p_lt_min;
    assign tail   = desc ? p_lt_min : p_gt_max;

    always_comb begin
        n_ll = r_ll;
        n_lr = r_lr;
        n_ul = r_ul;
        n_ur = r_ur;
        case (r_phase)
            P_FIND1: begin
                if (lead) begin
                    n_lr = r_mid - IW'(1);
                    n_ur = r_mid - IW'(1);
                end else if (tail) begin
                    n_ll = r_mid + IW'(1);
                    n_ul = r_mid + IW'(1);
                end else begin
                    n_lr = r_mid;
                    n_ul = r_mid;
                end
            end
            P_FIND2: begin
                if (lead) begin
                    n_ur = r_mid - IW'(1);
                end else if (tail) begin
                    n_ul = r_mid + IW'(1);
                end else begin
                    n_ul = r_mid;
                end
            end
            P_UP: begin
                if (go) n_ll = r_mid + IW'(1);
                else    n_lr = r_mid;
            end
            default: begin
                if (go) n_lr = r_mid - IW'(1);
                else    n_ll = r_mid;
            end
        endcase
    end

    // per-entry test of the linear pass
    assign in_rng = (r_pos2 >= r_lo) && (r_pos2 <= r_hi);
    always_comb begin
        if (ordered) begin
            hit = (r_kind == pimp_pkg::OP_NEQ) ? (!in_rng || !eq_min || !eq_max) : in_rng;
        end else begin
            case (r_kind)
                pimp_pkg::OP_EQ:  hit = !p_lt_min && !p_gt_max;
                pimp_pkg::OP_NEQ: hit = !eq_min || !eq_max;
                pimp_pkg::OP_GT:  hit = p_lt_max;
                pimp_pkg::OP_GE:  hit = !p_gt_max;
                pimp_pkg::OP_LT:  hit = p_gt_min;
                default:          hit = !p_lt_min;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_FIND1;
            r_bo        <= pimp_pkg::BO_NONE;
            r_pcnt      <= pimp_pkg::PCNT_RESET;
            r_nck       <= 1'b1;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pimp_pkg::CFG_BOUNDARY_ORDER:    r_bo   <= i_cfg_wdata[pimp_pkg::BO_W-1:0];
                    pimp_pkg::CFG_PAGE_COUNT:        r_pcnt <= i_cfg_wdata[pimp_pkg::PCNT_W-1:0];
                    pimp_pkg::CFG_NULL_COUNTS_KNOWN: r_nck  <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            // the done state reloads the output register itself
            if (r_out_valid && o_res.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (stat_we) begin
                        r_null_pg[i_req.page_slot]  <= i_req.page_all_null;
                        r_has_null[i_req.page_slot] <= i_req.page_has_nulls;
                        r_cnt <= append ? cnt0 + CW'(1) : cnt0;
                    end
                    if (query_beat) begin
                        r_op     <= i_req.query_op;
                        // set range starts with its ge pass
                        r_kind   <= (i_req.query_op == pimp_pkg::OP_RANGE) ?
                                    pimp_pkg::OP_GE : i_req.query_op;
                        r_second <= 1'b0;
                        r_probe  <= i_req.query_value[VALUE_WIDTH-1:0];
                        r_high   <= i_req.query_high[VALUE_WIDTH-1:0];
                        case (i_req.query_op)
                            pimp_pkg::OP_EQ: begin
                                if (i_req.value_is_null) begin
                                    r_res   <= r_nck ? r_has_null : all_mask;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_START;
                                end
                            end
                            pimp_pkg::OP_NEQ: begin
                                if (i_req.value_is_null) begin
                                    r_res   <= ~r_null_pg;
                                    r_state <= S_DONE;
                                end else if (!r_nck) begin
                                    r_res   <= all_mask;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_START;
                                end
                            end
                            pimp_pkg::OP_GT, pimp_pkg::OP_GE,
                            pimp_pkg::OP_LT, pimp_pkg::OP_LE,
                            pimp_pkg::OP_RANGE: r_state <= S_START;
                            default: begin
                                r_res   <= all_mask;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_START: begin
                    r_scan_pos <= '0;
                    r_mask     <= '0;
                    r_v1       <= 1'b0;
                    r_v2       <= 1'b0;
                    if (!ordered) begin
                        r_state <= S_SCAN;
                    end else if (r_kind == pimp_pkg::OP_EQ || r_kind == pimp_pkg::OP_NEQ) begin
                        r_phase <= P_FIND1;
                        r_ll    <= '0;
                        r_ul    <= '0;
                        r_lr    <= n_s - IW'(1);
                        r_ur    <= n_s - IW'(1);
                        r_state <= S_CHK;
                    end else if (r_cnt == '0) begin
                        r_lo    <= '0;
                        r_hi    <= '1;
                        r_state <= S_SCAN;
                    end else if (up) begin
                        r_phase <= P_UP;
                        r_ll    <= '0;
                        r_lr    <= n_s;
                        r_state <= S_CHK;
                    end else begin
                        r_phase <= P_DOWN;
                        r_ll    <= '1;
                        r_lr    <= n_s - IW'(1);
                        r_state <= S_CHK;
                    end
                end

                S_CHK: begin
                    if (c_fail) begin
                        // no run holds the probe: empty range
                        r_lo    <= '0;
                        r_hi    <= '1;
                        r_state <= S_SCAN;
                    end else begin
                        r_mid   <= c_mid;
                        r_state <= S_LIST;
                    end
                end

                S_LIST: r_state <= S_STAT;

                S_STAT: begin
                    r_ll    <= n_ll;
                    r_lr    <= n_lr;
                    r_ul    <= n_ul;
                    r_ur    <= n_ur;
                    case (r_phase)
                        P_FIND1: begin
                            if (n_ll == n_lr) r_phase <= P_FIND2;
                            r_state <= S_CHK;
                        end
                        P_FIND2: begin
                            if (n_ul == n_ur) begin
                                r_lo    <= n_ll;
                                r_hi    <= n_ur;
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_CHK;
                            end
                        end
                        P_UP: begin
                            if (!(n_ll < n_lr)) begin
                                r_lo    <= n_lr;
                                r_hi    <= n_s - IW'(1);
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_CHK;
                            end
                        end
                        default: begin
                            if (!(n_ll < n_lr)) begin
                                r_lo    <= '0;
                                r_hi    <= n_ll;
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_CHK;
                            end
                        end
                    endcase
                end

                S_SCAN: begin
                    // issue list read, then stat read, then test
                    r_v1   <= r_scan_pos < n_s;
                    r_pos1 <= r_scan_pos;
                    r_v2   <= r_v1;
                    r_pos2 <= r_pos1;
                    r_pg2  <= list_page;
                    if (r_scan_pos < n_s) begin
                        r_scan_pos <= r_scan_pos + IW'(1);
                    end
                    if (r_v2 && hit) begin
                        r_mask[r_pg2] <= 1'b1;
                    end
                    if (!(r_scan_pos < n_s) && !r_v1 && !r_v2) begin
                        r_state <= S_PASS_END;
                    end
                end

                S_PASS_END: begin
                    if (r_op == pimp_pkg::OP_RANGE && !r_second) begin
                        r_acc    <= r_mask;
                        r_second <= 1'b1;
                        r_kind   <= pimp_pkg::OP_LE;
                        r_probe  <= r_high;
                        r_state  <= S_START;
                    end else begin
                        case (r_op)
                            pimp_pkg::OP_NEQ:   r_res <= r_has_null | r_mask;
                            pimp_pkg::OP_RANGE: r_res <= r_acc & r_mask;
                            default:            r_res <= r_mask;
                        endcase
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_mask  <= r_res & all_mask;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.page_mask = r_out_mask;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // one request beat as the driver holds it
    typedef struct {
        logic                        req_type;
        logic [pimp_pkg::SLOT_W-1:0] page_slot;
        logic [63:0]                 page_min;
        logic [63:0]                 page_max;
        logic                        page_all_null;
        logic                        page_has_nulls;
        logic [pimp_pkg::OP_W-1:0]   query_op;
        logic [63:0]                 query_value;
        logic [63:0]                 query_high;
        logic                        value_is_null;
    } t_req_beat;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 400;     // idle time at the end of each drain

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [pimp_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [pimp_pkg::CFG_DATA_W-1:0] cfg_wdata;

    pimp_req_if req_if ();
    pimp_res_if res_if ();

    page_index_minmax_pruner i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // pending request beats, expected page masks
    t_req_beat   pending_beats[$];
    logic [63:0] mask_queue[$];
    int          err_count;
    bit          quiet;          // no idling in the final stretch

    // shadow of the block's page index
    longint      sh_min[64];
    longint      sh_max[64];
    logic [63:0] sh_null_pages;
    logic [63:0] sh_has_nulls;
    int          sh_list[64];
    int          sh_list_cnt;
    int          sh_order;
    int          sh_pcount;
    bit          sh_nck;
    longint      probe;

    // values used in the current page set, for query picks
    longint      set_vals[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // everything known from time zero
    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = pimp_pkg::CFG_BOUNDARY_ORDER;
        cfg_wdata            = '0;
        req_if.valid         = 1'b0;
        req_if.req_type      = pimp_pkg::REQ_LOAD;
        req_if.page_slot     = '0;
        req_if.page_min      = '0;
        req_if.page_max      = '0;
        req_if.page_all_null = 1'b0;
        req_if.page_has_nulls = 1'b0;
        req_if.query_op      = pimp_pkg::OP_EQ;
        req_if.query_value   = '0;
        req_if.query_high    = '0;
        req_if.value_is_null = 1'b0;
        res_if.ready         = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic int cmp_val(longint a, longint b);
        return a < b ? -1 : (b < a ? 1 : 0);
    endfunction

    // page at a list position, page 0 when out of range
    function automatic int list_page(int pos);
        if (pos < 0 || pos >= sh_list_cnt)
            return 0;
        return sh_list[pos];
    endfunction

    function automatic int probe_vs_min(int pos);
        return cmp_val(probe, sh_min[list_page(pos)]);
    endfunction

    function automatic int probe_vs_max(int pos);
        return cmp_val(probe, sh_max[list_page(pos)]);
    endfunction

    function automatic logic [63:0] list_span(int from, int to);
        logic [63:0] m;
        m = '0;
        for (int i = (from < 0 ? 0 : from); i < to && i < sh_list_cnt; i++)
            m[list_page(i)] = 1'b1;
        return m;
    endfunction

    function automatic logic [63:0] all_pages_mask();
        int n;
        n = sh_pcount > 64 ? 64 : sh_pcount;
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // descending order swaps the roles of min and max
    function automatic int lead_side(bit desc, int pos);
        return desc ? -probe_vs_max(pos) : probe_vs_min(pos);
    endfunction

    function automatic int tail_side(bit desc, int pos);
        return desc ? -probe_vs_min(pos) : probe_vs_max(pos);
    endfunction

    // run of listed pages whose range holds the probe
    function automatic bit locate_run(bit desc, output int lo, output int hi);
        int ll, ul, lr, ur, i;
        ll = 0; ul = 0; lr = sh_list_cnt - 1; ur = sh_list_cnt - 1;
        lo = 0; hi = 0;
        do begin
            if (ll > lr)
                return 1'b0;
            i = ll + (lr - ll) / 2;
            if (lead_side(desc, i) < 0) begin
                lr = i - 1; ur = i - 1;
            end else if (tail_side(desc, i) > 0) begin
                ll = i + 1; ul = i + 1;
            end else begin
                lr = i; ul = i;
            end
        end while (ll != lr);
        do begin
            if (ul > ur)
                return 1'b0;
            i = ul + (ur - ul + 1) / 2;
            if (lead_side(desc, i) < 0)
                ur = i - 1;
            else if (tail_side(desc, i) > 0)
                ul = i + 1;
            else
                ul = i;
        end while (ul != ur);
        lo = ll;
        hi = ur;
        return 1'b1;
    endfunction

    function automatic bit search_go(bit on_max, bit strict, int pos);
        int c;
        c = on_max ? probe_vs_max(pos) : probe_vs_min(pos);
        if (on_max)
            return strict ? (c >= 0) : (c > 0);
        return strict ? (c <= 0) : (c < 0);
    endfunction

    // listed pages matching one comparison kind
    function automatic logic [63:0] scan_pages(logic [pimp_pkg::OP_W-1:0] kind);
        int n, a, b, lo, hi, left, right, mid;
        bit t, desc, ok, up, strict, on_max;
        logic [63:0] m;
        n = sh_list_cnt;
        m = '0;
        if (sh_order != pimp_pkg::BO_ASC && sh_order != pimp_pkg::BO_DESC) begin
            for (int i = 0; i < n; i++) begin
                a = probe_vs_min(i);
                b = probe_vs_max(i);
                case (kind)
                    pimp_pkg::OP_EQ:  t = a >= 0 && b <= 0;
                    pimp_pkg::OP_NEQ: t = a != 0 || b != 0;
                    pimp_pkg::OP_GT:  t = b < 0;
                    pimp_pkg::OP_GE:  t = b <= 0;
                    pimp_pkg::OP_LT:  t = a > 0;
                    default:          t = a >= 0;
                endcase
                if (t)
                    m[list_page(i)] = 1'b1;
            end
            return m;
        end
        desc = sh_order == pimp_pkg::BO_DESC;
        if (kind == pimp_pkg::OP_EQ || kind == pimp_pkg::OP_NEQ) begin
            ok = locate_run(desc, lo, hi);
            if (kind == pimp_pkg::OP_EQ)
                return ok ? list_span(lo, hi + 1) : '0;
            if (!ok)
                return list_span(0, n);
            for (int i = 0; i < n; i++)
                if (i < lo || i > hi || probe_vs_min(i) != 0 || probe_vs_max(i) != 0)
                    m[list_page(i)] = 1'b1;
            return m;
        end
        if (n == 0)
            return '0;
        up     = (kind == pimp_pkg::OP_GT || kind == pimp_pkg::OP_GE) ? !desc : desc;
        strict = kind == pimp_pkg::OP_GT || kind == pimp_pkg::OP_LT;
        on_max = kind == pimp_pkg::OP_GT || kind == pimp_pkg::OP_GE;
        if (up) begin
            left = 0; right = n;
            do begin
                mid = left + (right - left) / 2;
                if (search_go(on_max, strict, mid))
                    left = mid + 1;
                else
                    right = mid;
            end while (left < right);
            return list_span(right, n);
        end
        left = -1; right = n - 1;
        do begin
            mid = left + (right - left + 1) / 2;
            if (search_go(on_max, strict, mid))
                right = mid - 1;
            else
                left = mid;
        end while (left < right);
        return list_span(0, left + 1);
    endfunction

    // apply one accepted beat to the shadow, queue the mask a query gives
    task automatic absorb_beat(t_req_beat b);
        int p;
        logic [63:0] all, m;
        if (b.req_type == pimp_pkg::REQ_LOAD) begin
            p = b.page_slot;
            if (p == 0)
                sh_list_cnt = 0;
            sh_min[p]        = b.page_min;
            sh_max[p]        = b.page_max;
            sh_null_pages[p] = b.page_all_null;
            sh_has_nulls[p]  = b.page_has_nulls;
            if (!b.page_all_null && sh_list_cnt < 64) begin
                sh_list[sh_list_cnt] = p;
                sh_list_cnt++;
            end
            return;
        end
        all   = all_pages_mask();
        probe = b.query_value;
        case (b.query_op)
            pimp_pkg::OP_EQ:
                if (b.value_is_null)
                    m = sh_nck ? sh_has_nulls : all;
                else
                    m = scan_pages(pimp_pkg::OP_EQ);
            pimp_pkg::OP_NEQ:
                if (b.value_is_null)
                    m = ~sh_null_pages;
                else if (!sh_nck)
                    m = all;
                else
                    m = sh_has_nulls | scan_pages(pimp_pkg::OP_NEQ);
            pimp_pkg::OP_GT, pimp_pkg::OP_GE, pimp_pkg::OP_LT, pimp_pkg::OP_LE:
                m = scan_pages(b.query_op);
            pimp_pkg::OP_RANGE: begin
                m = scan_pages(pimp_pkg::OP_GE);
                probe = b.query_high;
                m = m & scan_pages(pimp_pkg::OP_LE);
            end
            default:
                m = all;   // unused op code seven
        endcase
        mask_queue.push_back(m & all);
    endtask

    // ---------------- driver ----------------

    t_req_beat cur_beat;
    int        send_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready)
                absorb_beat(cur_beat);
            // a beat on offer stays until taken
            if (!(req_if.valid && !req_if.ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (!quiet && pending_beats.size() > 0
                             && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 15) - 1;
                    req_if.valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    cur_beat = pending_beats.pop_front();
                    req_if.req_type       <= cur_beat.req_type;
                    req_if.page_slot      <= cur_beat.page_slot;
                    req_if.page_min       <= cur_beat.page_min;
                    req_if.page_max       <= cur_beat.page_max;
                    req_if.page_all_null  <= cur_beat.page_all_null;
                    req_if.page_has_nulls <= cur_beat.page_has_nulls;
                    req_if.query_op       <= cur_beat.query_op;
                    req_if.query_value    <= cur_beat.query_value;
                    req_if.query_high     <= cur_beat.query_high;
                    req_if.value_is_null  <= cur_beat.value_is_null;
                    req_if.valid          <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    int          stall_left;
    logic [63:0] want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (mask_queue.size() == 0) begin
                    $display("%0t: unexpected mask beat, expected none, actual %h",
                             $time, res_if.page_mask);
                    err_count++;
                end else begin
                    want = mask_queue.pop_front();
                    if (res_if.page_mask !== want) begin
                        $display("%0t: page_mask mismatch, expected %h, actual %h",
                                 $time, want, res_if.page_mask);
                        err_count++;
                    end
                end
            end
            if (quiet) begin
                res_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------

    int cycle_cnt;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic longint near_val();
        return longint'(int'($urandom_range(0, 400)) - 200);
    endfunction

    function automatic longint pick_val();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && set_vals.size() > 0)
            return set_vals[$urandom_range(0, set_vals.size() - 1)];
        if (r < 8)
            return near_val();
        return longint'(rand64());
    endfunction

    task automatic push_load(int slot, longint mn, longint mx, bit an, bit hn);
        t_req_beat b;
        b = '{default: '0};
        b.req_type       = pimp_pkg::REQ_LOAD;
        b.page_slot      = slot[pimp_pkg::SLOT_W-1:0];
        b.page_min       = mn;
        b.page_max       = mx;
        b.page_all_null  = an;
        b.page_has_nulls = hn;
        b.query_op       = pimp_pkg::OP_W'($urandom_range(0, 7));
        b.query_value    = rand64();
        b.query_high     = rand64();
        b.value_is_null  = 1'($urandom_range(0, 1));
        pending_beats.push_back(b);
    endtask

    task automatic push_query(logic [pimp_pkg::OP_W-1:0] op, longint v, longint h, bit vn);
        t_req_beat b;
        b = '{default: '0};
        b.req_type       = pimp_pkg::REQ_QUERY;
        b.page_slot      = pimp_pkg::SLOT_W'($urandom_range(0, 63));
        b.page_min       = rand64();
        b.page_max       = rand64();
        b.page_all_null  = 1'($urandom_range(0, 1));
        b.page_has_nulls = 1'($urandom_range(0, 1));
        b.query_op       = op;
        b.query_value    = v;
        b.query_high     = h;
        b.value_is_null  = vn;
        pending_beats.push_back(b);
    endtask

    // pages 0..cnt-1 in order; min and max both follow the boundary order
    task automatic push_page_set(int cnt, int order, bit wide);
        longint s[$];
        longint mn, mx, t;
        int j;
        set_vals.delete();
        for (int i = 0; i < 2 * cnt; i++)
            s.push_back(wide ? longint'(rand64()) : near_val());
        s.sort();
        for (int i = 0; i < cnt; i++) begin
            j = (order == pimp_pkg::BO_DESC) ? cnt - 1 - i : i;
            mn = s[j];
            mx = s[j + cnt];
            if (order != pimp_pkg::BO_ASC && order != pimp_pkg::BO_DESC) begin
                mn = wide ? longint'(rand64()) : near_val();
                mx = wide ? longint'(rand64()) : near_val();
                if (mn > mx) begin
                    t = mn; mn = mx; mx = t;
                end
            end
            set_vals.push_back(mn);
            set_vals.push_back(mx);
            push_load(i, mn, mx, $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_reg(logic [pimp_pkg::CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= pimp_pkg::CFG_DATA_W'(val);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            pimp_pkg::CFG_BOUNDARY_ORDER: sh_order  = val & 3;
            pimp_pkg::CFG_PAGE_COUNT:     sh_pcount = val & 127;
            default:                      sh_nck    = 1'(val & 1);
        endcase
    endtask

    // every sent beat taken and every mask back, then let the block settle
    task automatic drain();
        while (pending_beats.size() > 0 || req_if.valid || mask_queue.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_regs(int order, int pcnt, bit nck);
        write_reg(pimp_pkg::CFG_BOUNDARY_ORDER, order);
        write_reg(pimp_pkg::CFG_PAGE_COUNT, pcnt);
        write_reg(pimp_pkg::CFG_NULL_COUNTS_KNOWN, nck);
    endtask

    // one random query, mostly near the loaded statistics
    task automatic push_rand_query();
        logic [pimp_pkg::OP_W-1:0] op;
        longint v, h;
        op = ($urandom_range(0, 19) == 0) ? pimp_pkg::OP_W'(7) :
             pimp_pkg::OP_W'($urandom_range(0, 6));
        v  = pick_val();
        h  = ($urandom_range(0, 4) == 0) ? pick_val() : v + longint'($urandom_range(0, 60));
        push_query(op, v, h, $urandom_range(0, 5) == 0);
    endtask

    int phase_order[12] = '{0, 1, 2, 1, 2, 3, 0, 1, 2, 0, 1, 2};
    int phase_pcnt[12]  = '{64, 64, 33, 1, 37, 127, 0, 20, 64, 5, 64, 64};
    bit phase_nck[12]   = '{1, 1, 0, 1, 1, 0, 1, 0, 1, 1, 0, 1};

    initial begin
        longint lo_v, hi_v;
        int cnt;
        err_count = 0;
        quiet = 1'b0;
        sh_null_pages = '0;
        sh_has_nulls = '0;
        sh_list_cnt = 0;
        sh_order = pimp_pkg::BO_NONE;
        sh_pcount = pimp_pkg::PCNT_RESET;
        sh_nck = 1'b1;
        for (int i = 0; i < 64; i++) begin
            sh_min[i] = 0; sh_max[i] = 0; sh_list[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every page written once, value extremes included
        lo_v = 64'sh8000_0000_0000_0000;
        hi_v = 64'sh7fff_ffff_ffff_ffff;
        push_load(0, lo_v, hi_v, 1'b0, 1'b1);
        push_load(1, lo_v, lo_v, 1'b0, 1'b0);
        for (int i = 2; i < 63; i++)
            push_load(i, near_val(), near_val() + 250, i % 9 == 4, i % 3 == 0);
        push_load(63, hi_v, hi_v, 1'b1, 1'b1);
        for (int op = 0; op < 8; op++) begin
            push_query(pimp_pkg::OP_W'(op), lo_v, hi_v, 1'b0);
            // null value, or an empty set range
            push_query(pimp_pkg::OP_W'(op), hi_v, lo_v, 1'b1);
        end
        push_query(pimp_pkg::OP_EQ, 0, 0, 1'b0);
        push_query(pimp_pkg::OP_NEQ, lo_v, 0, 1'b0);
        push_query(pimp_pkg::OP_RANGE, 50, -50, 1'b0);   // set minimum above maximum
        drain();

        // null counts unknown with the directed page set still loaded
        set_regs(pimp_pkg::BO_NONE, 64, 1'b0);
        push_query(pimp_pkg::OP_EQ, 0, 0, 1'b1);
        push_query(pimp_pkg::OP_NEQ, 7, 0, 1'b0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            set_regs(phase_order[ph], phase_pcnt[ph], phase_nck[ph]);
            if (ph == 11)
                quiet = 1'b1;
            cnt = (ph % 4 == 1) ? 64 : $urandom_range(1, 12);
            push_page_set(cnt, phase_order[ph], ph % 5 == 3);
            for (int q = 0; q < 12; q++) begin
                // some out-of-order reloads as noise
                if ($urandom_range(0, 19) == 0)
                    push_load($urandom_range(0, 63), near_val(), near_val(),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                    push_rand_query();
            end
            drain();
        end

        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
